// ===== hdl/bmplcd_pkg.sv =====
// shared constants, types and helpers of the bmp to lcd pixel converter
package bmplcd_pkg;

  localparam int DIM_BITS  = 16;
  localparam int POS_W     = 32;
  localparam int WORD_W    = 32;
  localparam int ROW_W     = 20;
  localparam int ROWIDX_W  = 16;
  localparam int PAD_W     = 16;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = 2 * DIM_BITS;
  localparam int CMP_W     = 34;
  localparam int QUO_W     = 32;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int WL3_W     = CFG_W + 2;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  localparam logic [POS_W-1:0] POS_OFFSET   = POS_W'(10);
  localparam logic [POS_W-1:0] POS_WIDTH    = POS_W'(18);
  localparam logic [POS_W-1:0] POS_HEIGHT   = POS_W'(22);
  localparam logic [POS_W-1:0] POS_RAW      = POS_W'(34);
  localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(37);

  localparam logic [WORD_W-1:0] MIN_OFFSET = WORD_W'(38);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROWS    = 1'b1;

  localparam logic [CFG_W-1:0] MAX_COLUMNS_RST = CFG_W'(320);
  localparam logic [CFG_W-1:0] MAX_ROWS_RST    = CFG_W'(240);

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] word;
    logic        pixel_done;
    logic        image_done;
  } result_t;

  typedef struct packed {
    logic fire;
    logic restart;
    logic hdr;
    logic pixel;
    logic reject;
    logic mul_load;
    logic div_start;
    logic pad_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sig_bad;
    logic hdr_end;
    logic hdr_bad;
    logic skip_end;
    logic pix_last;
    logic clip_empty;
    logic off_is_38;
    logic div_done;
    logic out_room;
  } dp_status_t;

  // drop byte b into little-endian lane of a header word
  function automatic logic [WORD_W-1:0] put_le(input logic [WORD_W-1:0] w,
                                               input logic [1:0] lane,
                                               input logic [7:0] b);
    logic [WORD_W-1:0] r;
    r = w;
    r[lane*8 +: 8] = b;
    return r;
  endfunction

endpackage

// ===== hdl/bmplcd_if.sv =====
// valid/ready channels for file bytes and display words
interface bmplcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bmplcd_word_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] display_word;
  logic        pixel_done;
  logic        image_done;

  modport source (output valid, output result_kind, output display_word,
                  output pixel_done, output image_done, input ready);
  modport sink (input valid, input result_kind, input display_word,
                input pixel_done, input image_done, output ready);
endinterface

// ===== hdl/bmplcd_div.sv =====
// restoring divider, one quotient bit per cycle
module bmplcd_div import bmplcd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [QUO_W-1:0]    dividend,
  input  logic [DIM_BITS-1:0] divisor,
  output logic [QUO_W-1:0]    quotient,
  output logic                done
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(QUO_W - 1);

  logic [DIM_BITS-1:0]  rem;
  logic [QUO_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIM_BITS:0]    shifted;
  logic                 fits;
  logic [DIM_BITS-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[QUO_W-1]};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? DIM_BITS'(shifted - {1'b0, divisor}) : DIM_BITS'(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== hdl/bmplcd_datapath.sv =====
// header capture, padding math, pixel walk and two-entry result buffer
module bmplcd_datapath import bmplcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  bmplcd_word_if.source        words
);

  logic [CFG_W-1:0]    max_columns;
  logic [CFG_W-1:0]    max_rows;
  logic [POS_W-1:0]    byte_position;
  logic [WORD_W-1:0]   pixel_start_offset;
  logic [WORD_W-1:0]   image_width;
  logic [WORD_W-1:0]   image_height;
  logic [WORD_W-1:0]   raw_data_size;
  logic [PAD_W-1:0]    row_padding;
  logic [ROWIDX_W-1:0] row_index;
  logic [ROW_W-1:0]    byte_in_row;
  logic [7:0]          held_blue;
  logic [7:0]          held_green;
  logic [1:0]          byte_in_pixel;
  logic [PROD_W-1:0]   prod;
  result_t             slot0;
  result_t             slot1;
  logic [1:0]          count;

  logic [POS_W-1:0]    pos_eff;
  logic [POS_W-1:0]    pos_plus1;
  logic [DIM_BITS-1:0] wid;
  logic [DIM_BITS-1:0] hgt;
  logic [CFG_W-1:0]    wl;
  logic [CFG_W-1:0]    hl;
  logic [WL3_W-1:0]    wl3;
  logic [ROW_W-1:0]    row_len;
  logic [ROW_W-1:0]    bir_inc;
  logic                row_end;
  logic                in_row;
  logic                emit;
  logic                last;
  logic [CMP_W-1:0]    need;
  logic [CMP_W-1:0]    raw_ext;
  logic [WORD_W-1:0]   diff;
  logic [QUO_W-1:0]    quo;
  logic                div_done;
  logic [PAD_W-1:0]    pad;
  logic                pop;
  logic                push_one;
  logic                push_two;
  result_t             res_a;
  result_t             res_b;

  bmplcd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (diff),
    .divisor  (hgt),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    pos_eff   = first_byte ? '0 : byte_position;
    pos_plus1 = byte_position + POS_W'(1);
    wid       = image_width[DIM_BITS-1:0];
    hgt       = image_height[DIM_BITS-1:0];

    // clip to the screen, live so register writes between bytes take effect
    wl      = (WORD_W'(wid) > WORD_W'(max_columns)) ? max_columns : CFG_W'(wid);
    hl      = (WORD_W'(hgt) > WORD_W'(max_rows)) ? max_rows : CFG_W'(hgt);
    wl3     = WL3_W'({wl, 1'b0}) + WL3_W'(wl);
    row_len = ROW_W'({wid, 1'b0}) + ROW_W'(wid) + ROW_W'(row_padding);
    bir_inc = byte_in_row + ROW_W'(1);
    row_end = bir_inc >= row_len;
    in_row  = byte_in_row < ROW_W'(wl3);
    emit    = in_row && (byte_in_pixel == 2'd2);
    last    = ((ROWIDX_W + 1)'(row_index) + (ROWIDX_W + 1)'(1) >= (ROWIDX_W + 1)'(hl))
              && (bir_inc == ROW_W'(wl3));

    // padding dividend: raw size less width*height*3, floored at zero
    need    = CMP_W'(prod) + (CMP_W'(prod) << 1);
    raw_ext = CMP_W'(raw_data_size);
    diff    = (raw_ext > need) ? WORD_W'(raw_ext - need) : '0;
    pad     = (|quo[QUO_W-1:PAD_W]) ? '1 : quo[PAD_W-1:0];

    status.sig_bad    = (pos_eff == POS_W'(0) && data_byte != SIG_B) ||
                        (pos_eff == POS_W'(1) && data_byte != SIG_M);
    status.hdr_end    = pos_eff == POS_HDR_LAST;
    status.hdr_bad    = (image_height == '0) || ((image_width >> DIM_BITS) != '0) ||
                        ((image_height >> DIM_BITS) != '0) ||
                        (pixel_start_offset < MIN_OFFSET);
    status.skip_end   = pos_plus1 >= pixel_start_offset;
    status.pix_last   = emit && last;
    status.clip_empty = (wid == '0) || (max_columns == '0) || (max_rows == '0);
    status.off_is_38  = pixel_start_offset == MIN_OFFSET;
    status.div_done   = div_done;
    status.out_room   = (count == 2'd0) || (count == 2'd1 && words.ready);

    push_one = cmd.reject;
    push_two = cmd.pixel && emit;
    pop      = words.valid && words.ready;

    res_a = '{kind: KIND_REJECT, word: 16'h0000, pixel_done: 1'b0, image_done: 1'b0};
    res_b = '{kind: KIND_WORD, word: {held_blue, 8'h00}, pixel_done: 1'b1,
              image_done: last};
    if (push_two) begin
      res_a = '{kind: KIND_WORD, word: {data_byte, held_green}, pixel_done: 1'b0,
                image_done: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_columns        <= MAX_COLUMNS_RST;
      max_rows           <= MAX_ROWS_RST;
      byte_position      <= '0;
      pixel_start_offset <= '0;
      image_width        <= '0;
      image_height       <= '0;
      raw_data_size      <= '0;
      row_padding        <= '0;
      row_index          <= '0;
      byte_in_row        <= '0;
      held_blue          <= '0;
      held_green         <= '0;
      byte_in_pixel      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_COLUMNS: max_columns <= cfg_data;
          REG_MAX_ROWS:    max_rows    <= cfg_data;
        endcase
      end

      if (cmd.fire) begin
        if (cmd.restart) begin
          byte_position <= POS_W'(1);
        end else if (byte_position != '1) begin
          byte_position <= pos_plus1;
        end
      end

      if (cmd.restart) begin
        pixel_start_offset <= '0;
        image_width        <= '0;
        image_height       <= '0;
        raw_data_size      <= '0;
        row_padding        <= '0;
        row_index          <= '0;
        byte_in_row        <= '0;
        held_blue          <= '0;
        held_green         <= '0;
        byte_in_pixel      <= '0;
      end else if (cmd.hdr) begin
        if (byte_position >= POS_OFFSET && byte_position <= POS_OFFSET + POS_W'(3)) begin
          pixel_start_offset <= put_le(pixel_start_offset,
                                       2'(byte_position - POS_OFFSET), data_byte);
        end else if (byte_position >= POS_WIDTH &&
                     byte_position <= POS_WIDTH + POS_W'(3)) begin
          image_width <= put_le(image_width, 2'(byte_position - POS_WIDTH), data_byte);
        end else if (byte_position >= POS_HEIGHT &&
                     byte_position <= POS_HEIGHT + POS_W'(3)) begin
          image_height <= put_le(image_height, 2'(byte_position - POS_HEIGHT), data_byte);
        end else if (byte_position >= POS_RAW &&
                     byte_position <= POS_RAW + POS_W'(3)) begin
          raw_data_size <= put_le(raw_data_size, 2'(byte_position - POS_RAW), data_byte);
        end
      end

      if (cmd.pixel) begin
        if (in_row) begin
          if (byte_in_pixel == 2'd0) begin
            held_blue     <= data_byte;
            byte_in_pixel <= 2'd1;
          end else if (byte_in_pixel == 2'd1) begin
            held_green    <= data_byte;
            byte_in_pixel <= 2'd2;
          end else begin
            byte_in_pixel <= 2'd0;
          end
        end
        // the final pixel leaves the row counters as they are
        if (!(emit && last)) begin
          if (row_end) begin
            byte_in_row   <= '0;
            byte_in_pixel <= 2'd0;
            row_index     <= row_index + ROWIDX_W'(1);
          end else begin
            byte_in_row <= bir_inc;
          end
        end
      end

      if (cmd.pad_load) begin
        row_padding <= pad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= wid * hgt;
    end
  end

  // result buffer: a push only comes when the buffer is empty or drains empty this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push_two) begin
      count <= 2'd2;
    end else if (push_one) begin
      count <= 2'd1;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_two || push_one) begin
      slot0 <= res_a;
      slot1 <= res_b;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign words.valid        = count != 2'd0;
  assign words.result_kind  = slot0.kind;
  assign words.display_word = slot0.word;
  assign words.pixel_done   = slot0.pixel_done;
  assign words.image_done   = slot0.image_done;

  a_push_into_empty: assert property (@(posedge clk) disable iff (rst)
    (push_one || push_two) |-> (count == 2'd0 || (count == 2'd1 && pop)))
    else $error("result pushed over a pending result");

  a_pixel_first_word: assert property (@(posedge clk) disable iff (rst)
    push_two |=> (words.valid && words.result_kind == KIND_WORD && !words.pixel_done))
    else $error("pixel did not present its first word");

endmodule

// ===== hdl/bmplcd_ctrl.sv =====
// parser phase and padding-computation sequencer
module bmplcd_ctrl import bmplcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       first_byte,
  input  dp_status_t status,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_SKIP    = 3'd1;
  localparam logic [2:0] ST_PIXEL   = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_MUL     = 3'd4;
  localparam logic [2:0] ST_DIVLOAD = 3'd5;
  localparam logic [2:0] ST_DIV     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] eff;
  logic       accepting;
  logic       fire;

  always_comb begin
    accepting = (state == ST_HEADER) || (state == ST_SKIP) ||
                (state == ST_PIXEL) || (state == ST_DONE);
    in_ready  = accepting && status.out_room;
    fire      = in_valid && in_ready;
    // a first byte restarts the parse in any phase that takes bytes
    eff       = first_byte ? ST_HEADER : state;

    cmd         = '0;
    cmd.fire    = fire;
    cmd.restart = fire && first_byte;
    state_next  = state;

    if (fire) begin
      unique case (eff) inside
        ST_HEADER: begin
          cmd.hdr = 1'b1;
          state_next = ST_HEADER;
          if (status.sig_bad) begin
            cmd.reject = 1'b1;
            state_next = ST_DONE;
          end else if (status.hdr_end) begin
            if (status.hdr_bad) begin
              cmd.reject = 1'b1;
              state_next = ST_DONE;
            end else begin
              state_next = ST_MUL;
            end
          end
        end
        ST_SKIP: begin
          if (status.skip_end) begin
            state_next = ST_PIXEL;
          end
        end
        ST_PIXEL: begin
          cmd.pixel = 1'b1;
          if (status.pix_last) begin
            state_next = ST_DONE;
          end
        end
        ST_DONE: begin
          state_next = ST_DONE;
        end
        default: begin
          state_next = ST_HEADER;
        end
      endcase
    end else begin
      unique case (state) inside
        ST_HEADER, ST_SKIP, ST_PIXEL, ST_DONE: begin
          state_next = state;
        end
        ST_MUL: begin
          cmd.mul_load = 1'b1;
          state_next = ST_DIVLOAD;
        end
        ST_DIVLOAD: begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end
        ST_DIV: begin
          if (status.div_done) begin
            cmd.pad_load = 1'b1;
            if (status.clip_empty) begin
              state_next = ST_DONE;
            end else if (status.off_is_38) begin
              state_next = ST_PIXEL;
            end else begin
              state_next = ST_SKIP;
            end
          end
        end
        default: begin
          state_next = ST_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

  a_mul_then_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_DIVLOAD))
    else $error("product not followed by divider load");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_DIVLOAD || state == ST_DIV) |-> !in_ready)
    else $error("byte taken during padding computation");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == ST_DIV))
    else $error("divider finished outside its wait state");

endmodule

// ===== hdl/bmp_stream_to_lcd_pixels.sv =====
// top level: 24-bit bmp byte stream to 16-bit display words
// output: the byte that completes a pixel (or rejects the image) shows its first word
//   in the cycle after its transfer; the second word of a pixel follows once the first is taken
// throughput: one byte per cycle outside pixel data while the result buffer has room; pixel data
//   pauses after each pixel while the two-entry result buffer drains one word per cycle when taken
// after the last header byte no byte is taken during the multiply and the 32-step divider
// reset: max_columns 320, max_rows 240, parser in header phase, result buffer empty
module bmp_stream_to_lcd_pixels import bmplcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bmplcd_byte_if.sink          bytes,
  bmplcd_word_if.source        words,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  bmplcd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (bytes.valid),
    .first_byte (bytes.first_byte),
    .status     (status),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  assign bytes.ready = in_ready;

  bmplcd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (bytes.data_byte),
    .first_byte (bytes.first_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .words      (words)
  );

endmodule
